// ----- hw/rtl/mtap_pkg.sv -----
// Shared types, codes and constants of the tape pulse player.
package mtap_pkg;

	// Default sizes
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam int DELAY_BITS_DEF  = 32;

	// Field and arithmetic widths
	localparam int BYTE_BITS   = 8;
	localparam int RAW_BITS    = 24;
	localparam int RATIO_BITS  = 24;
	localparam int FRAC_BITS   = 16;
	localparam int SHORT_SHIFT = 3;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [RATIO_BITS-1:0] RATIO_RESET = RATIO_BITS'(1 << FRAC_BITS);

	// Input item commands
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_BYTE   = 2'd1,
		CMD_MOTOR  = 2'd2,
		CMD_REWIND = 2'd3
	} cmd_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_WHOLE_WAVE  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLOCK_SCALE = 2'd1;

endpackage

// ----- hw/rtl/mtap_scale.sv -----
// Delay scaler: Q8.16 ratio multiply with round-half-up, doubling and saturation.
module mtap_scale import mtap_pkg::*; #(
	parameter int DELAY_BITS = DELAY_BITS_DEF
) (
	input  logic [RAW_BITS-1:0]   raw_delay,
	input  logic [RATIO_BITS-1:0] ratio,
	output logic [DELAY_BITS-1:0] scaled_delay
);

	localparam int PROD_W = RAW_BITS + RATIO_BITS;
	localparam int SUM_W  = PROD_W + 1;
	localparam int DBL_W  = SUM_W - FRAC_BITS + 1;
	localparam int SAT_W  = (DELAY_BITS > DBL_W) ? DELAY_BITS : DBL_W;
	localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);

	logic [PROD_W-1:0] product;
	logic [SUM_W-1:0]  rounded;
	logic [DBL_W-1:0]  doubled;
	logic [SAT_W-1:0]  dbl_ext;
	logic [SAT_W-1:0]  max_ext;

	// Multiply, round, drop the fraction and double
	assign product = raw_delay * ratio;
	assign rounded = SUM_W'(product) + ROUND_HALF;
	assign doubled = {rounded[SUM_W-1:FRAC_BITS], 1'b0};

	// Clamp to the largest count the timer holds
	assign dbl_ext = SAT_W'(doubled);
	assign max_ext = SAT_W'({DELAY_BITS{1'b1}});
	assign scaled_delay = (dbl_ext > max_ext) ? max_ext[DELAY_BITS-1:0]
		: dbl_ext[DELAY_BITS-1:0];

endmodule

// ----- hw/rtl/mtap_pulse_player_top.sv -----
// Top level of the tape pulse player: byte decoder, delay queue, pulse timer, result register.

// The block takes one transaction per clock cycle and returns one result for each, in the
// cycle after it is accepted; s_tready drops only while the result register is full and
// m_tready is low. That rate rests on the combinational state update, whose longest path is the
// 24 by 24 bit ratio multiply on the tape byte path that feeds the delay queue. Commands
// travel in s_tuser (0 tick, 1 tape byte, 2 motor, 3 rewind), the final image byte is
// marked by s_tlast. No clearing pass is needed after reset.
module mtap_pulse_player_top import mtap_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int DELAY_BITS  = DELAY_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// Configuration write channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [RATIO_BITS-1:0]   cfg_data,
	// Input stream
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [15:0]             s_tdata,  // [7:0] tape_byte, [8] motor_request, rest zero
	input  logic                    s_tlast,  // final_byte
	input  logic [1:0]              s_tuser,  // [1:0] command
	// Output stream
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [7:0]              m_tdata   // [0] cassette_level, [1] falling_edge,
	                                          // [2] motor_running, [3] byte_request,
	                                          // [4] underrun, rest zero
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	// Configuration registers
	logic                  whole_wave_q;
	logic [RATIO_BITS-1:0] ratio_q;

	// Player state
	logic                  level_q, level_d;
	logic [DELAY_BITS-1:0] phase_cnt_q, phase_cnt_d;
	logic [DELAY_BITS-1:0] second_q, second_d;
	logic [1:0]            byte_phase_q, byte_phase_d;
	logic [RAW_BITS-1:0]   asm_q, asm_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic                  motor_q, motor_d;
	logic                  ended_q, ended_d;
	logic [DELAY_BITS-1:0] queue_q [QUEUE_DEPTH];
	logic [DELAY_BITS-1:0] queue_d [QUEUE_DEPTH];

	// Result register
	logic                  out_valid_q;
	logic [4:0]            result_q;

	logic                  accept;
	cmd_t                  cmd;
	logic [BYTE_BITS-1:0]  tape_byte;
	logic                  motor_req;
	logic [RAW_BITS-1:0]   push_raw;
	logic [DELAY_BITS-1:0] push_scaled;
	logic                  push_en;
	logic                  pop_one;
	logic                  pop_two;
	logic                  fall;
	logic                  under;
	logic [DELAY_BITS-1:0] head_half;

	assign cmd       = cmd_t'(s_tuser);
	assign tape_byte = s_tdata[BYTE_BITS-1:0];
	assign motor_req = s_tdata[BYTE_BITS];

	// Take a transaction whenever the result register is free or draining
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// Raw delay pushed by this byte: short form or completed long form
	assign push_raw = (byte_phase_q == 2'd0)
		? RAW_BITS'({tape_byte, SHORT_SHIFT'(0)})
		: {tape_byte, asm_q[2*BYTE_BITS-1:0]};

	mtap_scale #(
		.DELAY_BITS(DELAY_BITS)
	) u_scale (
		.raw_delay   (push_raw),
		.ratio       (ratio_q),
		.scaled_delay(push_scaled)
	);

	assign head_half = queue_q[0] >> 1;

	// Next player state for the presented item
	always_comb begin
		level_d      = level_q;
		phase_cnt_d  = phase_cnt_q;
		second_d     = second_q;
		byte_phase_d = byte_phase_q;
		asm_d        = asm_q;
		count_d      = count_q;
		motor_d      = motor_q;
		ended_d      = ended_q;
		push_en      = 1'b0;
		pop_one      = 1'b0;
		pop_two      = 1'b0;
		fall         = 1'b0;
		under        = 1'b0;
		unique case (cmd)
			CMD_TICK: begin
				if (motor_q) begin
					priority if (phase_cnt_q != '0) begin
						phase_cnt_d = phase_cnt_q - DELAY_BITS'(1);
					end else if (!level_q) begin
						phase_cnt_d = second_q;
						level_d     = 1'b1;
					end else if (count_q == '0) begin
						under = 1'b1;
						if (ended_q) begin
							motor_d = 1'b0;
						end
					end else if (whole_wave_q) begin
						pop_one     = 1'b1;
						phase_cnt_d = head_half;
						second_d    = queue_q[0] - head_half;
					end else if (count_q >= CNT_W'(2)) begin
						pop_two     = 1'b1;
						phase_cnt_d = queue_q[0];
						second_d    = queue_q[1];
					end else if (ended_q) begin
						pop_one     = 1'b1;
						phase_cnt_d = queue_q[0];
						second_d    = '0;
					end else begin
						under = 1'b1;
					end
					// Start a wave: drive low, stop the motor when the image runs dry
					if (pop_one || pop_two) begin
						fall    = 1'b1;
						level_d = 1'b0;
						count_d = pop_two ? count_q - CNT_W'(2) : count_q - CNT_W'(1);
						if (ended_q && count_d == '0) begin
							motor_d = 1'b0;
						end
					end
				end
			end
			CMD_BYTE: begin
				if (!ended_q && count_q < CNT_W'(QUEUE_DEPTH)) begin
					if (byte_phase_q == 2'd0) begin
						if (tape_byte != '0) begin
							push_en = 1'b1;
						end else begin
							byte_phase_d = 2'd1;
							asm_d        = '0;
						end
					end else begin
						unique case (byte_phase_q)
							2'd1:    asm_d[BYTE_BITS-1:0]             = tape_byte;
							2'd2:    asm_d[2*BYTE_BITS-1:BYTE_BITS]   = tape_byte;
							default: asm_d[3*BYTE_BITS-1:2*BYTE_BITS] = tape_byte;
						endcase
						if (byte_phase_q == 2'd3) begin
							push_en      = 1'b1;
							byte_phase_d = 2'd0;
							asm_d        = '0;
						end else begin
							byte_phase_d = byte_phase_q + 2'd1;
						end
					end
					if (push_en) begin
						count_d = count_q + CNT_W'(1);
					end
					// Image end drops any partial long delay
					if (s_tlast) begin
						ended_d      = 1'b1;
						byte_phase_d = 2'd0;
						asm_d        = '0;
					end
				end
			end
			CMD_MOTOR: begin
				motor_d = motor_req;
			end
			CMD_REWIND: begin
				level_d      = 1'b1;
				phase_cnt_d  = '0;
				second_d     = '0;
				byte_phase_d = 2'd0;
				asm_d        = '0;
				count_d      = '0;
				ended_d      = 1'b0;
			end
		endcase
	end

	// Next queue contents: shift out on a pop, write at the fill point on a push
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			queue_d[i] = queue_q[i];
			if (pop_one) begin
				queue_d[i] = queue_q[IDX_W'((i + 1) % QUEUE_DEPTH)];
			end else if (pop_two) begin
				queue_d[i] = queue_q[IDX_W'((i + 2) % QUEUE_DEPTH)];
			end
		end
		if (push_en) begin
			queue_d[count_q[IDX_W-1:0]] = push_scaled;
		end
	end

	// Hold configuration; the user is to write it only while idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_wave_q <= 1'b0;
			ratio_q      <= RATIO_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_WHOLE_WAVE) begin
				whole_wave_q <= cfg_data[0];
			end else if (cfg_index == REG_CLOCK_SCALE) begin
				ratio_q <= cfg_data;
			end
		end
	end

	// Advance player state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= 1'b1;
			phase_cnt_q  <= '0;
			second_q     <= '0;
			byte_phase_q <= 2'd0;
			asm_q        <= '0;
			count_q      <= '0;
			motor_q      <= 1'b0;
			ended_q      <= 1'b0;
		end else if (accept) begin
			level_q      <= level_d;
			phase_cnt_q  <= phase_cnt_d;
			second_q     <= second_d;
			byte_phase_q <= byte_phase_d;
			asm_q        <= asm_d;
			count_q      <= count_d;
			motor_q      <= motor_d;
			ended_q      <= ended_d;
		end
	end

	// Queue storage, valid only below the fill count
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				queue_q[i] <= queue_d[i];
			end
		end
	end

	// Result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Capture the result of the accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= {under, count_d < CNT_W'(QUEUE_DEPTH), motor_d, fall, level_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, result_q};

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("delay queue count beyond depth");

	a_no_partial_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_phase_q != 2'd0) |-> !ended_q)
		else $error("long delay assembly open after image end");

	a_edge_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[1]) |-> (!m_tdata[0] && !m_tdata[4]))
		else $error("falling edge with high level or underrun");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted transaction produced no result");

endmodule

// ----- sim/mtap_pulse_player_top_tb.sv -----
// Self-checking testbench of the tape pulse player: directed table, random phases, line predictor.
module mtap_pulse_player_top_tb;
	import mtap_pkg::*;

	localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEF;
	localparam int DELAY_BITS  = DELAY_BITS_DEF;
	localparam logic [63:0] DELAY_MAX  = (64'd1 << DELAY_BITS) - 64'd1;
	localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_BITS - 1);
	localparam int N_DIRECTED   = 28;
	localparam int N_SETTINGS   = 9;
	localparam int PHASE_ITEMS  = 215;
	localparam int REPORT_LIMIT = 10;
	localparam int STALL_LIMIT  = 2000;

	typedef logic [DELAY_BITS-1:0] delay_t;

	// Readout of the cassette line, bit 4 first
	typedef struct packed {
		logic underrun;
		logic byte_request;
		logic motor_running;
		logic falling_edge;
		logic cassette_level;
	} readout_t;

	// One input transaction, with an optional typed-in readout
	typedef struct {
		cmd_t           cmd;
		logic [7:0]     tape_byte;
		logic           final_byte;
		logic           motor_request;
		logic           pinned;
		readout_t       pin;
	} tape_item_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_SPARSE,
		RX_PATTERN,
		RX_CHOKED
	} rx_mode_t;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [RATIO_BITS-1:0]   cfg_data;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [15:0]             s_tdata;  // [7:0] tape_byte, [8] motor_request, rest zero
	logic                    s_tlast;  // final_byte
	logic [1:0]              s_tuser;  // [1:0] command
	logic                    m_tvalid;
	logic                    m_tready;
	logic [7:0]              m_tdata;  // [0] cassette_level, [1] falling_edge,
	                                   // [2] motor_running, [3] byte_request, [4] underrun

	// Player state as predicted from accepted transactions
	logic                    tp_whole_wave;
	logic [RATIO_BITS-1:0]   tp_ratio;
	logic                    tp_level;
	delay_t                  tp_count;
	delay_t                  tp_second;
	logic [1:0]              tp_byte_phase;
	logic [RAW_BITS-1:0]     tp_long;
	delay_t                  tp_queue[QUEUE_DEPTH];
	int                      tp_queued;
	logic                    tp_motor;
	logic                    tp_ended;

	readout_t    readouts_due[$];
	tape_item_t  tx_item;
	tape_item_t  directed_plan[N_DIRECTED];
	int unsigned mismatch_count = 0;
	int unsigned item_count = 0;
	int unsigned readout_count = 0;
	int unsigned fall_count = 0;
	int unsigned underrun_count = 0;
	int unsigned reg_write_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned rx_left = 0;
	int unsigned rx_tick = 0;
	rx_mode_t    rx_mode = RX_OPEN;

	mtap_pulse_player_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic readout_t res(input logic lvl, input logic fall, input logic motor,
			input logic req, input logic under);
		return '{underrun: under, byte_request: req, motor_running: motor,
			falling_edge: fall, cassette_level: lvl};
	endfunction

	function automatic tape_item_t row(input cmd_t c, input logic [7:0] b, input logic f,
			input logic m);
		return '{cmd: c, tape_byte: b, final_byte: f, motor_request: m, pinned: 1'b0, pin: '0};
	endfunction

	function automatic tape_item_t rowp(input cmd_t c, input logic [7:0] b, input logic f,
			input logic m, input readout_t r);
		tape_item_t it;
		it = row(c, b, f, m);
		it.pinned = 1'b1;
		it.pin = r;
		return it;
	endfunction

	// Drop queue, decoder and image end; park the line high
	function automatic void clear_tape();
		tp_level = 1'b1;
		tp_count = '0;
		tp_second = '0;
		tp_byte_phase = '0;
		tp_long = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++)
			tp_queue[i] = '0;
		tp_queued = 0;
		tp_ended = 1'b0;
	endfunction

	// Scale by the clock ratio with rounding, double, saturate, and queue if there is room
	function automatic void queue_delay(input logic [RAW_BITS-1:0] raw);
		logic [63:0] scaled;
		scaled = ((64'(raw) * 64'(tp_ratio) + ROUND_HALF) >> FRAC_BITS) << 1;
		if (tp_queued < QUEUE_DEPTH) begin
			tp_queue[tp_queued] = (scaled > DELAY_MAX) ? delay_t'(DELAY_MAX) : delay_t'(scaled);
			tp_queued++;
		end
	endfunction

	function automatic delay_t take_delay();
		delay_t d;
		d = tp_queue[0];
		for (int i = 1; i < QUEUE_DEPTH; i++)
			tp_queue[i-1] = tp_queue[i];
		tp_queue[QUEUE_DEPTH-1] = '0;
		if (tp_queued > 0)
			tp_queued--;
		return d;
	endfunction

	// Advance the player by one transaction and return its readout
	function automatic readout_t play_item(input tape_item_t it);
		logic   fall;
		logic   under;
		delay_t d;
		fall = 1'b0;
		under = 1'b0;
		case (it.cmd)
			CMD_TICK: begin
				if (tp_motor) begin
					if (tp_count != 0) begin
						tp_count--;
					end else if (!tp_level) begin
						tp_count = tp_second;
						tp_level = 1'b1;
					end else if (tp_queued == 0) begin
						under = 1'b1;
						if (tp_ended)
							tp_motor = 1'b0;
					end else if (!tp_whole_wave && tp_queued < 2 && !tp_ended) begin
						under = 1'b1;
					end else begin
						if (tp_whole_wave) begin
							d = take_delay();
							tp_count = d >> 1;
							tp_second = d - tp_count;
						end else if (tp_queued >= 2) begin
							tp_count = take_delay();
							tp_second = take_delay();
						end else begin
							tp_count = take_delay();
							tp_second = '0;
						end
						tp_level = 1'b0;
						fall = 1'b1;
						if (tp_ended && tp_queued == 0)
							tp_motor = 1'b0;
					end
				end
			end
			CMD_BYTE: begin
				if (!tp_ended && tp_queued < QUEUE_DEPTH) begin
					if (tp_byte_phase == 0) begin
						if (it.tape_byte != 0) begin
							queue_delay(RAW_BITS'(it.tape_byte) << SHORT_SHIFT);
						end else begin
							tp_byte_phase = 2'd1;
							tp_long = '0;
						end
					end else begin
						tp_long |= RAW_BITS'(it.tape_byte) << (BYTE_BITS * (tp_byte_phase - 1));
						if (tp_byte_phase == 2'd3) begin
							queue_delay(tp_long);
							tp_byte_phase = '0;
							tp_long = '0;
						end else begin
							tp_byte_phase++;
						end
					end
					if (it.final_byte) begin
						tp_ended = 1'b1;
						tp_byte_phase = '0;
						tp_long = '0;
					end
				end
			end
			CMD_MOTOR: tp_motor = it.motor_request;
			default: clear_tape();
		endcase
		return res(tp_level, fall, tp_motor, tp_queued < QUEUE_DEPTH, under);
	endfunction

	// Draw a random transaction, mostly well-formed tape data interleaved with ticks
	function automatic tape_item_t pick_item();
		tape_item_t  it;
		int unsigned roll;
		logic        queue_full;
		it = row(CMD_TICK, 8'($urandom), $urandom_range(0, 39) == 0, 1'($urandom));
		roll = $urandom_range(0, 99);
		queue_full = (tp_queued >= QUEUE_DEPTH);
		if (roll < 2 || (tp_ended && !tp_motor && roll < 30)) begin
			it.cmd = CMD_REWIND;
		end else if (roll < 5 || (!tp_motor && roll < 25)) begin
			it.cmd = CMD_MOTOR;
			it.motor_request = ($urandom_range(0, 9) != 0);
		end else if (roll < (queue_full ? 12 : 45)) begin
			it.cmd = CMD_BYTE;
			// Keep long delays short most of the time so pulses keep flowing
			case (tp_byte_phase)
				2'd0: it.tape_byte = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
				2'd1: it.tape_byte = 8'($urandom);
				2'd2: it.tape_byte = ($urandom_range(0, 9) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, 3));
				default: it.tape_byte = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'd0;
			endcase
		end
		return it;
	endfunction

	function automatic void flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: %s", $time, msg);
	endfunction

	function automatic void check_field(input string name, input logic want, input logic got,
			input int unsigned seq);
		if (got !== want)
			flag_error($sformatf("readout %0d: %s expected %0b, got %0b", seq, name, want, got));
	endfunction

	// Predict on every accepted transaction, check every accepted readout
	always @(posedge clk) begin : monitor
		readout_t got;
		readout_t want;
		if (cfg_valid && cfg_ready) begin
			reg_write_count++;
			if (cfg_index == REG_WHOLE_WAVE)
				tp_whole_wave = cfg_data[0];
			else if (cfg_index == REG_CLOCK_SCALE)
				tp_ratio = cfg_data;
		end
		if (s_tvalid && s_tready) begin
			want = play_item(tx_item);
			if (tx_item.pinned)
				want = tx_item.pin;
			readouts_due.push_back(want);
			item_count++;
		end
		if (m_tvalid && m_tready) begin
			got = m_tdata[4:0];
			readout_count++;
			fall_count += got.falling_edge;
			underrun_count += got.underrun;
			if (readouts_due.size() == 0) begin
				flag_error($sformatf("readout %0d arrived with nothing pending: %05b",
					readout_count, got));
			end else begin
				want = readouts_due.pop_front();
				check_field("cassette_level", want.cassette_level, got.cassette_level,
					readout_count);
				check_field("falling_edge", want.falling_edge, got.falling_edge, readout_count);
				check_field("motor_running", want.motor_running, got.motor_running,
					readout_count);
				check_field("byte_request", want.byte_request, got.byte_request, readout_count);
				check_field("underrun", want.underrun, got.underrun, readout_count);
			end
		end
	end

	// End the run when no channel moves for too long
	always @(posedge clk) begin : watchdog
		if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("mtap_pulse_player_top_tb: done, errors");
			$finish;
		end
	end

	// Stall the readout side on its own schedule
	always @(negedge clk) begin : receiver
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(20, 160);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_OPEN:    m_tready <= 1'b1;
			RX_SPARSE:  m_tready <= ($urandom_range(0, 9) >= 3);
			RX_PATTERN: m_tready <= (rx_tick % 8 != 5) && (rx_tick % 8 != 6);
			default:    m_tready <= ($urandom_range(0, 9) >= 8);
		endcase
	end

	// Present a transaction and hold it until accepted; call right after a falling edge
	task automatic drive_item(input tape_item_t it);
		tx_item = it;
		s_tvalid <= 1'b1;
		s_tuser <= it.cmd;
		s_tdata <= {7'd0, it.motor_request, it.tape_byte};
		s_tlast <= it.final_byte;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_input(input int unsigned cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic wait_drained();
		while (readouts_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [RATIO_BITS-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic                  wave_plan[N_SETTINGS];
		logic [RATIO_BITS-1:0] ratio_plan[N_SETTINGS];
		int unsigned           burst_left;
		int unsigned           gap;
		logic                  gapless;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = CMD_TICK;
		m_tready = 1'b0;
		tx_item = row(CMD_TICK, 8'd0, 1'b0, 1'b0);
		tp_whole_wave = 1'b0;
		tp_ratio = RATIO_RESET;
		tp_motor = 1'b0;
		clear_tape();

		// Directed walk in half-wave mode at unit ratio
		directed_plan = '{
			rowp(CMD_TICK,   8'h00, 1'b0, 1'b0, res(1, 0, 0, 1, 0)),  // motor off, no change
			rowp(CMD_MOTOR,  8'h00, 1'b0, 1'b1, res(1, 0, 1, 1, 0)),
			rowp(CMD_TICK,   8'h00, 1'b0, 1'b0, res(1, 0, 1, 1, 1)),  // empty queue
			rowp(CMD_BYTE,   8'hFF, 1'b0, 1'b0, res(1, 0, 1, 1, 0)),
			rowp(CMD_TICK,   8'h00, 1'b0, 1'b0, res(1, 0, 1, 1, 1)),  // only one half queued
			rowp(CMD_BYTE,   8'h01, 1'b0, 1'b0, res(1, 0, 1, 0, 0)),  // queue now full
			rowp(CMD_BYTE,   8'h55, 1'b1, 1'b0, res(1, 0, 1, 0, 0)),  // dropped, end mark too
			rowp(CMD_TICK,   8'h00, 1'b0, 1'b0, res(0, 1, 1, 1, 0)),  // falling edge
			row (CMD_TICK,   8'h00, 1'b0, 1'b0),
			rowp(CMD_REWIND, 8'h00, 1'b0, 1'b0, res(1, 0, 1, 1, 0)),
			rowp(CMD_BYTE,   8'h00, 1'b0, 1'b0, res(1, 0, 1, 1, 0)),  // long delay opens
			rowp(CMD_BYTE,   8'h02, 1'b0, 1'b0, res(1, 0, 1, 1, 0)),
			rowp(CMD_BYTE,   8'h00, 1'b1, 1'b0, res(1, 0, 1, 1, 0)),  // end inside long delay
			rowp(CMD_BYTE,   8'h07, 1'b0, 1'b0, res(1, 0, 1, 1, 0)),  // after image end
			rowp(CMD_TICK,   8'h00, 1'b0, 1'b0, res(1, 0, 0, 1, 1)),  // exhausted, motor stops
			rowp(CMD_MOTOR,  8'h00, 1'b0, 1'b0, res(1, 0, 0, 1, 0)),
			rowp(CMD_REWIND, 8'h00, 1'b0, 1'b0, res(1, 0, 0, 1, 0)),
			rowp(CMD_MOTOR,  8'h00, 1'b0, 1'b1, res(1, 0, 1, 1, 0)),
			row (CMD_BYTE,   8'h00, 1'b0, 1'b0),
			row (CMD_BYTE,   8'h03, 1'b0, 1'b0),
			row (CMD_BYTE,   8'h00, 1'b0, 1'b0),
			row (CMD_BYTE,   8'h00, 1'b0, 1'b0),
			rowp(CMD_BYTE,   8'h10, 1'b1, 1'b0, res(1, 0, 1, 0, 0)),
			rowp(CMD_TICK,   8'h00, 1'b0, 1'b0, res(0, 1, 0, 1, 0)),  // last wave stops motor
			row (CMD_MOTOR,  8'h00, 1'b0, 1'b1),
			rowp(CMD_REWIND, 8'h00, 1'b0, 1'b0, res(1, 0, 1, 1, 0)),
			rowp(CMD_BYTE,   8'h80, 1'b1, 1'b0, res(1, 0, 1, 1, 0)),
			rowp(CMD_TICK,   8'h00, 1'b0, 1'b0, res(0, 1, 0, 1, 0))   // lone half after end
		};

		// Register settings of the random phases, extremes first
		wave_plan  = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
		ratio_plan = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h000800, 24'h000400,
			24'($urandom_range(0, 4095)), RATIO_RESET, 24'h002000, 24'($urandom)};

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_WHOLE_WAVE, '0);
		write_reg(REG_CLOCK_SCALE, RATIO_RESET);
		for (int i = 0; i < N_DIRECTED; i++) begin
			@(negedge clk);
			drive_item(directed_plan[i]);
		end

		for (int ph = 0; ph < N_SETTINGS; ph++) begin
			// Hold the stream until every readout is back, then retune
			idle_input(1);
			wait_drained();
			write_reg(REG_WHOLE_WAVE, RATIO_BITS'(wave_plan[ph]));
			write_reg(REG_CLOCK_SCALE, ratio_plan[ph]);
			gapless = ($urandom_range(0, 3) == 0);
			burst_left = 0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap = gapless ? 0 : $urandom_range(0, 6);
					if (gap != 0)
						idle_input(gap);
				end
				burst_left--;
				if ($urandom_range(0, 199) == 0) begin
					idle_input(1);
					wait_drained();
				end
				@(negedge clk);
				drive_item(pick_item());
			end
		end

		idle_input(1);
		wait_drained();
		repeat (8) @(posedge clk);
		if (readouts_due.size() != 0)
			flag_error($sformatf("%0d readouts never arrived", readouts_due.size()));

		$display("Sent %0d transactions (%0d directed), checked %0d readouts over %0d settings.",
			item_count, N_DIRECTED, readout_count, N_SETTINGS + 1);
		$display("Saw %0d falling edges, %0d underruns, %0d register writes, %0d mismatches.",
			fall_count, underrun_count, reg_write_count, mismatch_count);
		if (mismatch_count == 0) begin
			$display("mtap_pulse_player_top_tb: done, clean");
		end else begin
			$display("mtap_pulse_player_top_tb: done, errors");
		end
		$finish;
	end

endmodule
